### hw/rtl/smam_pkg.sv
// Shared constants, codes and types of the stack with middle access.
package smam_pkg;

  localparam int DEPTH   = 16;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int TOTAL_W = 5;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [TOTAL_W-1:0]       total_t;

  localparam word_t MID_EMPTY = '1;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELMID = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic  push_en;
    logic  pop_en;
    logic  del_en;
    logic  nxt_nonzero;
    cnt_t  count;
    cnt_t  mid;
    cnt_t  mid_nxt;
    word_t word;
  } cell_ctrl_t;

  function automatic total_t to_total(input cnt_t cnt);
    logic [CNT_W+TOTAL_W-1:0] wide;
    wide = {{TOTAL_W{1'b0}}, cnt};
    return wide[TOTAL_W-1:0];
  endfunction

endpackage

### hw/rtl/smam_ifs.sv
// Valid/ready channel interfaces for commands and results.
interface smam_cmd_if
  import smam_pkg::*;
  ();
  logic  valid;
  logic  ready;
  logic [1:0] cmd;
  word_t push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface smam_res_if
  import smam_pkg::*;
  ();
  logic    valid;
  logic    ready;
  word_t   popped_value;
  logic    popped_valid;
  word_t   middle_value;
  total_t  entry_total;
  status_e status;

  modport source (output valid, output popped_value, output popped_valid,
                  output middle_value, output entry_total, output status,
                  input ready);
  modport sink   (input valid, input popped_value, input popped_valid,
                  input middle_value, input entry_total, input status,
                  output ready);
endinterface

### hw/rtl/smam_cell.sv
// One stack cell: holds a word, loads a push, shifts down from its upper neighbor.
module smam_cell
  import smam_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  idx_t       idx,
  input  word_t      upper_data,
  output word_t      data,
  output word_t      pop_tap,
  output word_t      mid_tap
);

  word_t data_r;
  word_t data_nxt;
  cnt_t  pos;
  cnt_t  pos_up;

  assign pos    = CNT_W'(idx);
  assign pos_up = pos + CNT_W'(1);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push_en && pos == ctrl.count) begin
      data_nxt = ctrl.word;
    end else if (ctrl.del_en && pos >= ctrl.mid && pos_up < ctrl.count) begin
      data_nxt = upper_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign pop_tap = (ctrl.pop_en && pos_up == ctrl.count) ? data_r : '0;
  assign mid_tap = (ctrl.nxt_nonzero && pos == ctrl.mid_nxt) ? data_nxt : '0;

endmodule

### hw/rtl/stack_with_middle_access_top.sv
// Top level of the stack with middle access: control, cell row and result register.
// Result valid is registered: it rises in the cycle after the command transfer.
// Throughput: one command per cycle while out_chan is not stalled; every command,
// delete-middle included, needs no extra states because all cells shift in parallel.
// Reset: synchronous active-low rst_n clears the entry count and result valid;
// cell contents are not reset and are never read before they are written.
module stack_with_middle_access_top
  import smam_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  smam_cmd_if.sink   in_chan,
  smam_res_if.source out_chan
);

  cnt_t       count_r;
  cnt_t       count_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  word_t      popped_value_r;
  logic       popped_valid_r;
  word_t      middle_value_r;
  total_t     entry_total_r;
  status_e    status_r;
  status_e    status_nxt;
  logic       xfer;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;
  word_t      pop_or;
  word_t      mid_or;
  word_t      cell_data [DEPTH];
  word_t      cell_up   [DEPTH];
  word_t      pop_taps  [DEPTH];
  word_t      mid_taps  [DEPTH];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign xfer  = in_chan.valid && in_chan.ready;
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    ctrl         = '0;
    ctrl.word    = in_chan.push_value;
    ctrl.count   = count_r;
    ctrl.mid     = count_r >> 1;
    status_nxt   = ST_OK;
    count_nxt    = count_r;
    if (xfer) begin
      case (in_chan.cmd)
        CMD_PUSH: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.push_en = 1'b1;
            count_nxt    = count_r + CNT_W'(1);
          end
        end
        CMD_POP, CMD_DELMID: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctrl.pop_en = (in_chan.cmd == CMD_POP);
            ctrl.del_en = (in_chan.cmd == CMD_DELMID);
            count_nxt   = count_r - CNT_W'(1);
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
    ctrl.mid_nxt     = count_nxt >> 1;
    ctrl.nxt_nonzero = (count_nxt != '0);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      assign cell_up[i] = '0;
    end else begin : g_mid
      assign cell_up[i] = cell_data[i+1];
    end

    smam_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(i)),
      .upper_data (cell_up[i]),
      .data       (cell_data[i]),
      .pop_tap    (pop_taps[i]),
      .mid_tap    (mid_taps[i])
    );
  end

  always_comb begin
    pop_or = '0;
    mid_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pop_or = pop_or | pop_taps[i];
      mid_or = mid_or | mid_taps[i];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      popped_value_r <= pop_or;
      popped_valid_r <= ctrl.pop_en;
      middle_value_r <= ctrl.nxt_nonzero ? mid_or : MID_EMPTY;
      entry_total_r  <= to_total(count_nxt);
      status_r       <= status_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.popped_value = popped_value_r;
  assign out_chan.popped_valid = popped_valid_r;
  assign out_chan.middle_value = middle_value_r;
  assign out_chan.entry_total  = entry_total_r;
  assign out_chan.status       = status_r;

endmodule

### hw/rtl/smam_checker.sv
// Port-level assertions for the stack with middle access, bound to the top level.
module smam_checker
  import smam_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input word_t   out_popped_value,
  input logic    out_popped_valid,
  input word_t   out_middle_value,
  input total_t  out_entry_total,
  input status_e out_status
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("command transfer without result");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_popped_value) &&
      $stable(out_popped_valid) && $stable(out_middle_value) &&
      $stable(out_entry_total) && $stable(out_status)))
    else $error("stalled result changed");

  a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |->
      (out_entry_total == '0 && !out_popped_valid && out_middle_value == MID_EMPTY))
    else $error("empty refusal with stored entries");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_popped_valid) |-> (out_status == ST_OK))
    else $error("popped word with refusal status");

endmodule

bind stack_with_middle_access_top smam_checker u_smam_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_popped_value (out_chan.popped_value),
  .out_popped_valid (out_chan.popped_valid),
  .out_middle_value (out_chan.middle_value),
  .out_entry_total  (out_chan.entry_total),
  .out_status       (out_chan.status)
);
